@@ design/mafs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and header tables of the MPEG audio / ADTS frame synchronizer.
// Depends on nothing; every other file of the block imports it.
package mafs_pkg;

  // lookahead window and queue sizes
  localparam int WINDOW_BYTES = 7;
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W        = 13;

  // header sizes per stream format
  localparam int HDR_MP3_BYTES  = 4;
  localparam int HDR_ADTS_BYTES = 7;

  // stream format codes
  localparam logic FMT_MP3  = 1'b0;
  localparam logic FMT_ADTS = 1'b1;

  // mpeg version codes of the layer iii header
  localparam logic [1:0] VER_25   = 2'd0;
  localparam logic [1:0] VER_RSVD = 2'd1;
  localparam logic [1:0] VER_2    = 2'd2;
  localparam logic [1:0] VER_1    = 2'd3;
  localparam logic [1:0] LAYER_3  = 2'd1;

  // sample-rate families
  localparam logic [1:0] SR_44K1 = 2'd0;
  localparam logic [1:0] SR_48K  = 2'd1;
  localparam logic [1:0] SR_32K  = 2'd2;
  localparam logic [1:0] SR_RSVD = 2'd3;

  typedef logic [7:0]          byte_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef byte_t               hdr_bytes_t [HDR_ADTS_BYTES];

  // item from the window to the frame tracker: byte plus header length (0 = no header)
  typedef struct packed {
    byte_t data;
    len_t  hdr_len;
  } mafs_item_t;

  // bitrate tables in kbit/s
  localparam logic [8:0] KBPS_V1 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
  };
  localparam logic [8:0] KBPS_V2 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
  };

  // frame length without padding for the 44.1 kHz family, mpeg-1 and mpeg-2
  localparam len_t LEN441_V1 [16] = '{
    13'd0,              13'(1440 * 32 / 441),  13'(1440 * 40 / 441),
    13'(1440 * 48 / 441),  13'(1440 * 56 / 441),  13'(1440 * 64 / 441),
    13'(1440 * 80 / 441),  13'(1440 * 96 / 441),  13'(1440 * 112 / 441),
    13'(1440 * 128 / 441), 13'(1440 * 160 / 441), 13'(1440 * 192 / 441),
    13'(1440 * 224 / 441), 13'(1440 * 256 / 441), 13'(1440 * 320 / 441),
    13'd0
  };
  localparam len_t LEN441_V2 [16] = '{
    13'd0,              13'(1440 * 8 / 441),   13'(1440 * 16 / 441),
    13'(1440 * 24 / 441),  13'(1440 * 32 / 441),  13'(1440 * 40 / 441),
    13'(1440 * 48 / 441),  13'(1440 * 56 / 441),  13'(1440 * 64 / 441),
    13'(1440 * 80 / 441),  13'(1440 * 96 / 441),  13'(1440 * 112 / 441),
    13'(1440 * 128 / 441), 13'(1440 * 144 / 441), 13'(1440 * 160 / 441),
    13'd0
  };
  // mpeg-2.5 at 11.025 kHz
  localparam len_t LEN441_V25 [16] = '{
    13'd0,              13'(2880 * 8 / 441),   13'(2880 * 16 / 441),
    13'(2880 * 24 / 441),  13'(2880 * 32 / 441),  13'(2880 * 40 / 441),
    13'(2880 * 48 / 441),  13'(2880 * 56 / 441),  13'(2880 * 64 / 441),
    13'(2880 * 80 / 441),  13'(2880 * 96 / 441),  13'(2880 * 112 / 441),
    13'(2880 * 128 / 441), 13'(2880 * 144 / 441), 13'(2880 * 160 / 441),
    13'd0
  };

endpackage

@@ design/mpeg_audio_frame_sync_core.sv @@
`timescale 1ns / 1ps
// Top level of the MPEG audio / ADTS frame synchronizer.
// Depends on mafs_pkg, mafs_front, mafs_fifo and mafs_back.
//
//  channel   ports                                   request moved
//  ------    ------------------------------------   ------------------------------
//  input     push, full, in_data_byte                one stream byte
//  result    pop, empty, out_byte, out_frame_*       one frame byte with marks
//  config    cfg_valid, cfg_ready, cfg_stream_format stream format (0 mp3, 1 adts)
//
// One byte per cycle is sustained while the queue is not full: the front checks the header
// over the window and the appended byte in the cycle it accepts, and the back retires one
// queued item per cycle while its result register is free or popped. A result byte passes
// through the window, the item queue and the result register; header lag is H-1 bytes.
// Reset (rst_n low, synchronous) empties the window, queue and result register; no sweep.
// full rises when the four-entry item queue is full; a stalled result holds the back.
module mpeg_audio_frame_sync_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  mafs_pkg::byte_t in_data_byte,
  output logic            empty,
  input  logic            pop,
  output mafs_pkg::byte_t out_byte,
  output logic            out_frame_start,
  output logic            out_frame_last,
  output mafs_pkg::len_t  out_frame_length,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_stream_format
);
  import mafs_pkg::*;

  logic       accept;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  mafs_item_t q_wdata;
  mafs_item_t q_rdata;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  // window and header check
  mafs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_fmt   (cfg_stream_format),
    .accept    (accept),
    .data_byte (in_data_byte),
    .q_push    (q_push),
    .q_item    (q_wdata)
  );

  // decoupling queue
  mafs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // frame tracker and result register
  mafs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (q_rdata),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_frame_start  (out_frame_start),
    .out_frame_last   (out_frame_last),
    .out_frame_length (out_frame_length)
  );

endmodule

@@ design/mafs_hdr.sv @@
`timescale 1ns / 1ps
// Header checker: validates a layer iii or adts header and gives its frame length.
// Depends on mafs_pkg for the bitrate and length tables.
module mafs_hdr (
  input  logic                fmt,
  input  mafs_pkg::hdr_bytes_t hdr,
  output mafs_pkg::len_t      frame_bytes
);
  import mafs_pkg::*;

  logic [1:0] ver;
  logic [1:0] lay;
  logic [3:0] bri;
  logic [1:0] sri;
  logic       pad;
  logic       mp3_ok;
  logic [8:0] br;
  len_t       br_w;
  len_t       m3;
  len_t       m9;
  len_t       mp3_base;
  len_t       mp3_len;
  len_t       adts_raw;
  logic       adts_ok;

  // layer iii field split
  assign ver = hdr[1][4:3];
  assign lay = hdr[1][2:1];
  assign bri = hdr[2][7:4];
  assign sri = hdr[2][3:2];
  assign pad = hdr[2][1];

  assign mp3_ok = (hdr[0] == 8'hFF) && (hdr[1][7:5] == 3'b111) && (ver != VER_RSVD) &&
                  (lay == LAYER_3) && (bri != 4'd0) && (bri != 4'd15) && (sri != SR_RSVD);

  // bitrate multiples for the 48 kHz and 32 kHz families
  assign br   = (ver == VER_1) ? KBPS_V1[bri] : KBPS_V2[bri];
  assign br_w = {{(LEN_W - 9){1'b0}}, br};
  assign m3   = br_w + (br_w << 1);
  assign m9   = (br_w << 3) + br_w;

  always_comb begin
    case (sri)
      SR_44K1: begin
        if (ver == VER_1) mp3_base = LEN441_V1[bri];
        else if (ver == VER_2) mp3_base = LEN441_V2[bri];
        else mp3_base = LEN441_V25[bri];
      end
      SR_48K:  mp3_base = (ver == VER_25) ? (m3 << 1) : m3;
      SR_32K:  mp3_base = (ver == VER_25) ? m9 : (m9 >> 1);
      default: mp3_base = '0;
    endcase
  end

  assign mp3_len = mp3_base + {{(LEN_W - 1){1'b0}}, pad};

  // adts length field spans bytes three to five
  assign adts_raw = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
  assign adts_ok  = (hdr[0] == 8'hFF) && ((hdr[1] & 8'hF6) == 8'hF0) &&
                    (adts_raw >= len_t'(HDR_ADTS_BYTES));

  always_comb begin
    if (fmt == FMT_ADTS) frame_bytes = adts_ok ? adts_raw : '0;
    else frame_bytes = mp3_ok ? mp3_len : '0;
  end

endmodule

@@ design/mafs_front.sv @@
`timescale 1ns / 1ps
// Front part: lookahead window, stream format register and header check per byte.
// Depends on mafs_pkg and mafs_hdr; feeds the item queue.
module mafs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_fmt,
  input  logic                accept,
  input  mafs_pkg::byte_t     data_byte,
  output logic                q_push,
  output mafs_pkg::mafs_item_t q_item
);
  import mafs_pkg::*;

  byte_t      win_r   [WINDOW_BYTES];
  byte_t      win_nxt [WINDOW_BYTES];
  byte_t      ext     [WINDOW_BYTES];
  fill_t      fill_r;
  fill_t      fill_nxt;
  fill_t      fill_a;
  fill_t      wr_sel;
  fill_t      hlen;
  logic       fmt_r;
  logic       emit;
  hdr_bytes_t hdr;
  len_t       hdr_len;

  // window with the incoming byte appended
  assign wr_sel = (fill_r == fill_t'(WINDOW_BYTES)) ? fill_t'(WINDOW_BYTES - 1) : fill_r;
  assign fill_a = (fill_r == fill_t'(WINDOW_BYTES)) ? fill_r : fill_r + fill_t'(1);

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      ext[i] = (fill_t'(i) == wr_sel) ? data_byte : win_r[i];
    end
  end

  // header check over the oldest bytes
  assign hlen = (fmt_r == FMT_ADTS) ? fill_t'(HDR_ADTS_BYTES) : fill_t'(HDR_MP3_BYTES);
  assign emit = (fill_a >= hlen);

  always_comb begin
    for (int i = 0; i < HDR_ADTS_BYTES; i++) begin
      hdr[i] = ext[i];
    end
  end

  mafs_hdr u_hdr (
    .fmt         (fmt_r),
    .hdr         (hdr),
    .frame_bytes (hdr_len)
  );

  // shift out the oldest byte once a header's worth is present
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      win_nxt[i] = emit ? ext[i + 1] : ext[i];
    end
    win_nxt[WINDOW_BYTES - 1] = ext[WINDOW_BYTES - 1];
    fill_nxt = emit ? fill_a - fill_t'(1) : fill_a;
  end

  assign q_push         = accept && emit;
  assign q_item.data    = ext[0];
  assign q_item.hdr_len = hdr_len;

  // window storage
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // fill count and format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      fmt_r  <= FMT_MP3;
    end else begin
      if (accept) fill_r <= fill_nxt;
      if (cfg_we) fmt_r <= cfg_fmt;
    end
  end

endmodule

@@ design/mafs_fifo.sv @@
`timescale 1ns / 1ps
// Item queue between the window front and the frame tracker.
// Depends on mafs_pkg for the item type and depth.
module mafs_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mafs_pkg::mafs_item_t wdata,
  output logic                 full,
  input  logic                 pop,
  output mafs_pkg::mafs_item_t rdata,
  output logic                 empty
);
  import mafs_pkg::*;

  mafs_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCNT_W'(1);
    end
  end

  // count stays within depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  // pointers coincide when the queue is empty or full
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

@@ design/mafs_back.sv @@
`timescale 1ns / 1ps
// Back part: frame tracker that drops stray bytes, marks frame start and last byte,
// and holds the result register. Depends on mafs_pkg.
module mafs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mafs_pkg::mafs_item_t q_item,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output mafs_pkg::byte_t      out_byte,
  output logic                 out_frame_start,
  output logic                 out_frame_last,
  output mafs_pkg::len_t       out_frame_length
);
  import mafs_pkg::*;

  len_t  rem_r;
  len_t  cur_len_r;
  logic  out_valid_r;
  byte_t out_byte_r;
  logic  out_start_r;
  logic  out_last_r;
  len_t  out_len_r;
  logic  can_take;
  logic  in_frame;
  logic  take;
  len_t  rem_load;
  len_t  rem_dec;

  assign can_take = !out_valid_r || pop;
  assign q_pop    = !q_empty && can_take;
  assign in_frame = (rem_r != '0);
  assign take     = q_pop && (in_frame || (q_item.hdr_len != '0));
  assign rem_load = in_frame ? rem_r : q_item.hdr_len;
  assign rem_dec  = rem_load - len_t'(1);

  // frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      cur_len_r <= '0;
    end else if (take) begin
      rem_r <= rem_dec;
      if (!in_frame) cur_len_r <= q_item.hdr_len;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r  <= q_item.data;
      out_start_r <= !in_frame;
      out_last_r  <= (rem_dec == '0);
      out_len_r   <= in_frame ? cur_len_r : q_item.hdr_len;
    end
  end

  assign empty            = !out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_frame_start  = out_start_r;
  assign out_frame_last   = out_last_r;
  assign out_frame_length = out_len_r;

  // remaining count stays below the frame length
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) |-> (rem_r < cur_len_r))
    else $error("remaining count not below frame length");

  // a waiting start byte leaves length minus one bytes to go
  a_start_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_start_r) |-> ((14'(rem_r) + 14'd1) == 14'(out_len_r)))
    else $error("start byte disagrees with remaining count");

  // a waiting last byte means the frame is closed
  a_last_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (rem_r == '0))
    else $error("last byte while frame still open");

endmodule
